// ===== rtl/core/rspg_pkg.sv =====
// shared types and constants of the ring sector polygon generator
`default_nettype none
package rspg_pkg;

	localparam int IN_DATA_W  = 88;
	localparam int OUT_DATA_W = 56;
	localparam int COORD_W    = 14;

	// restoring divider: 36 bit dividend, divisor below 2^27
	localparam int DIV_W     = 36;
	localparam int DEN_W     = 27;
	localparam int DIV_STEPS = DIV_W;

	// angles in Q30 radians
	localparam logic [26:0] PI30     = 27'd112441981;
	localparam logic [30:0] HALFPI   = 31'd1686629713;
	localparam logic [30:0] QUARTPI  = 31'd843314856;
	localparam logic [30:0] ONE30    = 31'd1073741824;
	localparam logic [35:0] RED_BIAS = 36'd26986075408;
	localparam logic [49:0] HALF_Q34 = 50'd8589934592;

	// floor(2^50 / PI30), step count estimate from the Q12 span
	localparam logic [23:0] SEG_RCP = 24'(64'd1125899906842624 / 64'd112441981);

	// horner divisors, sine first then cosine
	localparam int N_COEF    = 9;
	localparam int SIN_LAST  = 3;
	localparam int COS_FIRST = 4;
	localparam int COS_LAST  = 8;

	localparam logic [6:0] COEF_DIV [N_COEF] = '{
		7'd72, 7'd42, 7'd20, 7'd6, 7'd90, 7'd56, 7'd30, 7'd12, 7'd2
	};

	// floor(2^32 / d)
	localparam logic [31:0] COEF_RCP [N_COEF] = '{
		32'(64'd4294967296 / 64'd72), 32'(64'd4294967296 / 64'd42),
		32'(64'd4294967296 / 64'd20), 32'(64'd4294967296 / 64'd6),
		32'(64'd4294967296 / 64'd90), 32'(64'd4294967296 / 64'd56),
		32'(64'd4294967296 / 64'd30), 32'(64'd4294967296 / 64'd12),
		32'(64'd4294967296 / 64'd2)
	};

	typedef enum logic [4:0] {
		OP_NONE,
		OP_SEG_INIT,
		OP_SEG_COR,
		OP_DIV_STEP,
		OP_SEG_SET,
		OP_QR_SET,
		OP_RED_INIT,
		OP_RED_STEP,
		OP_FOLD,
		OP_SQR,
		OP_LDP,
		OP_RCP,
		OP_COR,
		OP_MULT,
		OP_SOUT,
		OP_QUAD,
		OP_SCX,
		OP_FINX,
		OP_SCY,
		OP_FINY,
		OP_EMIT,
		OP_FWD,
		OP_TURN,
		OP_BACK
	} dp_op_t;

	typedef struct packed {
		dp_op_t     op;
		logic [2:0] shift;
		logic [3:0] coef;
	} dp_cmd_t;

	typedef struct packed {
		logic inner;
		logic at_seg;
		logic at_zero;
		logic odd_point;
		logic out_busy;
	} dp_sts_t;

endpackage
`default_nettype wire

// ===== rtl/core/rspg_ctrl.sv =====
// sequencer of the ring sector polygon generator
`default_nettype none
module rspg_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  rspg_pkg::dp_sts_t      sts,
	output rspg_pkg::dp_cmd_t      cmd
);
	import rspg_pkg::*;

	localparam int CNT_W = $clog2(DIV_STEPS);

	typedef enum logic [4:0] {
		S_IDLE,
		S_SEGINIT,
		S_SEGCOR,
		S_SEGSET,
		S_QDIV,
		S_QRSET,
		S_REDINIT,
		S_RED,
		S_FOLD,
		S_SQR,
		S_LDP,
		S_RCP,
		S_COR,
		S_MUL,
		S_SOUT,
		S_QUAD,
		S_SCX,
		S_FINX,
		S_SCY,
		S_FINY,
		S_WAIT,
		S_EMIT,
		S_STEP
	} state_t;

	state_t           state_q;
	dp_cmd_t          cmd_q;
	logic [CNT_W-1:0] cnt_q;
	dp_op_t           walk_op;
	logic             last_point;

	assign walk_op    = sts.inner ? OP_BACK : (sts.at_seg ? OP_TURN : OP_FWD);
	assign last_point = sts.inner && sts.at_zero;
	assign s_tready   = (state_q == S_IDLE);
	assign cmd        = cmd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cmd_q.op    <= OP_NONE;
			cmd_q.shift <= '0;
			cmd_q.coef  <= '0;
			cnt_q       <= '0;
		end else begin
			cmd_q.op <= OP_NONE;
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						state_q  <= S_SEGINIT;
						cmd_q.op <= OP_SEG_INIT;
					end
				end
				S_SEGINIT: begin
					state_q  <= S_SEGCOR;
					cmd_q.op <= OP_SEG_COR;
				end
				S_SEGCOR: begin
					state_q  <= S_SEGSET;
					cmd_q.op <= OP_SEG_SET;
				end
				S_SEGSET: begin
					state_q  <= S_QDIV;
					cmd_q.op <= OP_DIV_STEP;
					cnt_q    <= '0;
				end
				S_QDIV: begin
					if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
						state_q  <= S_QRSET;
						cmd_q.op <= OP_QR_SET;
					end else begin
						cnt_q    <= cnt_q + 1'b1;
						cmd_q.op <= OP_DIV_STEP;
					end
				end
				S_QRSET: begin
					state_q  <= S_REDINIT;
					cmd_q.op <= OP_RED_INIT;
				end
				S_REDINIT: begin
					state_q     <= S_RED;
					cmd_q.op    <= OP_RED_STEP;
					cmd_q.shift <= 3'd4;
				end
				S_RED: begin
					if (cmd_q.shift == 3'd0) begin
						state_q  <= S_FOLD;
						cmd_q.op <= OP_FOLD;
					end else begin
						cmd_q.shift <= cmd_q.shift - 1'b1;
						cmd_q.op    <= OP_RED_STEP;
					end
				end
				S_FOLD: begin
					state_q  <= S_SQR;
					cmd_q.op <= OP_SQR;
				end
				S_SQR: begin
					state_q    <= S_LDP;
					cmd_q.op   <= OP_LDP;
					cmd_q.coef <= '0;
				end
				S_LDP: begin
					state_q  <= S_RCP;
					cmd_q.op <= OP_RCP;
				end
				S_RCP: begin
					state_q  <= S_COR;
					cmd_q.op <= OP_COR;
				end
				S_COR: begin
					if (cmd_q.coef == 4'(SIN_LAST)) begin
						state_q  <= S_SOUT;
						cmd_q.op <= OP_SOUT;
					end else if (cmd_q.coef == 4'(COS_LAST)) begin
						state_q  <= S_QUAD;
						cmd_q.op <= OP_QUAD;
					end else begin
						state_q    <= S_MUL;
						cmd_q.op   <= OP_MULT;
						cmd_q.coef <= cmd_q.coef + 1'b1;
					end
				end
				S_MUL: begin
					state_q  <= S_RCP;
					cmd_q.op <= OP_RCP;
				end
				S_SOUT: begin
					state_q    <= S_LDP;
					cmd_q.op   <= OP_LDP;
					cmd_q.coef <= 4'(COS_FIRST);
				end
				S_QUAD: begin
					state_q  <= S_SCX;
					cmd_q.op <= OP_SCX;
				end
				S_SCX: begin
					state_q  <= S_FINX;
					cmd_q.op <= OP_FINX;
				end
				S_FINX: begin
					state_q  <= S_SCY;
					cmd_q.op <= OP_SCY;
				end
				S_SCY: begin
					state_q  <= S_FINY;
					cmd_q.op <= OP_FINY;
				end
				S_FINY: begin
					if (sts.odd_point) begin
						state_q <= S_WAIT;
					end else begin
						state_q  <= S_STEP;
						cmd_q.op <= walk_op;
					end
				end
				S_WAIT: begin
					if (!sts.out_busy) begin
						state_q  <= S_EMIT;
						cmd_q.op <= OP_EMIT;
					end
				end
				S_EMIT: begin
					if (last_point) begin
						state_q <= S_IDLE;
					end else begin
						state_q  <= S_STEP;
						cmd_q.op <= walk_op;
					end
				end
				S_STEP: begin
					state_q  <= S_REDINIT;
					cmd_q.op <= OP_RED_INIT;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/rspg_dp.sv =====
// datapath: divider, angle walk, range reduction, polynomials, scaling, output word
`default_nettype none
module rspg_dp #(
	parameter int MAX_POINTS = 128
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  rspg_pkg::dp_cmd_t                    cmd,
	output rspg_pkg::dp_sts_t                    sts,
	input  wire logic                            load,
	input  wire logic [rspg_pkg::IN_DATA_W-1:0]  s_tdata,
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	output logic [rspg_pkg::OUT_DATA_W-1:0]      m_tdata,
	output logic                                 m_tlast
);
	import rspg_pkg::*;

	localparam int CAP   = MAX_POINTS / 2 - 1;
	localparam int SEG_W = $clog2(MAX_POINTS / 2);

	// held item
	logic [11:0]        cx_q, cy_q;
	logic [15:0]        rin_q, rout_q;
	logic signed [33:0] a0_q;
	logic signed [16:0] span_q;

	// step count estimate and its remainder
	logic [7:0]         seg_est_q;
	logic [27:0]        seg_rem_q;

	// divider
	logic [DEN_W-1:0] div_rem_q, div_den_q;
	logic [DIV_W-1:0] div_quo_q;

	// angle walk
	logic [SEG_W-1:0]   seg_q, r_q, i_q;
	logic [SEG_W:0]     num_q;
	logic signed [35:0] q_q, off_q;
	logic               inner_q, odd_q;

	// trig
	logic [35:0]        red_v_q;
	logic [1:0]         quad_q;
	logic [29:0]        x_q, x2_q;
	logic               swap_q;
	logic [30:0]        p_q, qr_q, t_q, sin_q;
	logic signed [31:0] c_q, s_q;
	logic signed [48:0] prod_q;
	logic [COORD_W-1:0] px_q, py_q, fx_q, fy_q;

	// output word
	logic               m_tvalid_q, o_last_q;
	logic [COORD_W-1:0] o_fx_q, o_fy_q, o_sx_q, o_sy_q;

	logic               span_pos;
	logic signed [34:0] span30;
	logic [DIV_W-1:0]   span_u;
	logic [39:0]        seg_rcp_prod;
	logic [34:0]        seg_rem_full;
	logic [8:0]         seg_full;
	logic [DEN_W:0]     trial;
	logic               trial_ge;
	logic               seg_sat;
	logic [SEG_W-1:0]   seg_new;
	logic signed [36:0] ang;
	logic [35:0]        red_init, red_cand;
	logic [30:0]        res;
	logic [59:0]        sqr_prod;
	logic [62:0]        rcp_prod;
	logic [37:0]        qd, cor_rem;
	logic               cor_inc;
	logic [30:0]        t_new;
	logic [60:0]        x2t_prod, xt_prod;
	logic [30:0]        cc, ss;
	logic signed [31:0] cc_s, ss_s;
	logic [15:0]        rad;
	logic [49:0]        fin_v, fin_mag;
	logic [15:0]        fin_sh, fin_r;
	logic [COORD_W-1:0] coord_x, coord_y;
	logic [SEG_W:0]     fwd_sum, fwd_num;
	logic               fwd_wrap;
	logic [SEG_W+1:0]   back_diff, back_fix;
	logic               back_borrow;

	assign span_pos = (span_q > 17'sd0);
	assign span30   = {span_q, 18'b0};
	assign span_u   = {2'b0, span30[33:0]};

	// estimate is floor(span / (pi/30)) or one below it, the remainder settles both
	assign seg_rcp_prod = span_q[15:0] * SEG_RCP;
	assign seg_rem_full = {1'b0, span_q[15:0], 18'b0} - seg_est_q * PI30;
	assign seg_full     = {1'b0, seg_est_q} + {8'b0, (seg_rem_q > 28'd0)}
		+ {8'b0, (seg_rem_q > {1'b0, PI30})};

	assign trial    = {div_rem_q, div_quo_q[DIV_W-1]};
	assign trial_ge = (trial >= {1'b0, div_den_q});

	assign seg_sat = (seg_full > 9'(CAP));
	assign seg_new = !span_pos ? SEG_W'(1) : (seg_sat ? SEG_W'(CAP) : seg_full[SEG_W-1:0]);

	assign ang      = {{3{a0_q[33]}}, a0_q} + {off_q[35], off_q};
	assign red_init = ang[35:0] + RED_BIAS;
	assign red_cand = {5'b0, HALFPI} << cmd.shift;

	assign res      = red_v_q[30:0];
	assign sqr_prod = x_q * x_q;
	assign rcp_prod = p_q * COEF_RCP[cmd.coef];

	// reciprocal quotient is at most one short
	assign qd      = qr_q * COEF_DIV[cmd.coef];
	assign cor_rem = {7'b0, p_q} - qd;
	assign cor_inc = (cor_rem >= {31'b0, COEF_DIV[cmd.coef]});
	assign t_new   = ONE30 - (qr_q + {30'b0, cor_inc});

	assign x2t_prod = x2_q * t_q;
	assign xt_prod  = x_q * t_q;

	assign cc   = swap_q ? sin_q : t_q;
	assign ss   = swap_q ? t_q : sin_q;
	assign cc_s = $signed({1'b0, cc});
	assign ss_s = $signed({1'b0, ss});

	assign rad = inner_q ? rin_q : rout_q;

	// round half up, then truncate toward zero
	assign fin_v   = {prod_q[48], prod_q} + HALF_Q34;
	assign fin_mag = fin_v[49] ? (~fin_v + 1'b1) : fin_v;
	assign fin_sh  = fin_mag[49:34];
	assign fin_r   = fin_v[49] ? (~fin_sh + 1'b1) : fin_sh;
	assign coord_x = {2'b0, cx_q} + fin_r[COORD_W-1:0];
	assign coord_y = {2'b0, cy_q} + fin_r[COORD_W-1:0];

	assign fwd_sum  = num_q + {1'b0, r_q};
	assign fwd_wrap = (fwd_sum >= {1'b0, seg_q});
	assign fwd_num  = fwd_wrap ? (fwd_sum - {1'b0, seg_q}) : fwd_sum;

	assign back_diff   = {1'b0, num_q} - {2'b0, r_q};
	assign back_borrow = back_diff[SEG_W+1];
	assign back_fix    = back_borrow ? (back_diff + {2'b0, seg_q}) : back_diff;

	assign sts.inner     = inner_q;
	assign sts.at_seg    = (i_q == seg_q);
	assign sts.at_zero   = (i_q == '0);
	assign sts.odd_point = odd_q;
	assign sts.out_busy  = m_tvalid_q && !m_tready;

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {o_sy_q, o_sx_q, o_fy_q, o_fx_q};
	assign m_tlast  = o_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
			inner_q    <= 1'b0;
			odd_q      <= 1'b0;
			i_q        <= '0;
		end else begin
			if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (cmd.op)
				OP_QR_SET: begin
					i_q     <= '0;
					inner_q <= 1'b0;
					odd_q   <= 1'b0;
				end
				OP_EMIT: begin
					m_tvalid_q <= 1'b1;
				end
				OP_FWD: begin
					i_q   <= i_q + 1'b1;
					odd_q <= ~odd_q;
				end
				OP_TURN: begin
					inner_q <= 1'b1;
					odd_q   <= ~odd_q;
				end
				OP_BACK: begin
					i_q   <= i_q - 1'b1;
					odd_q <= ~odd_q;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cx_q   <= s_tdata[11:0];
			cy_q   <= s_tdata[23:12];
			rin_q  <= s_tdata[39:24];
			rout_q <= s_tdata[55:40];
			a0_q   <= {s_tdata[71:56], 18'b0};
			span_q <= $signed({s_tdata[87], s_tdata[87:72]})
				- $signed({s_tdata[71], s_tdata[71:56]});
		end
		case (cmd.op)
			OP_SEG_INIT: begin
				seg_est_q <= seg_rcp_prod[39:32];
			end
			OP_SEG_COR: begin
				seg_rem_q <= seg_rem_full[27:0];
			end
			OP_DIV_STEP: begin
				div_rem_q <= trial_ge ? DEN_W'(trial - {1'b0, div_den_q})
					: trial[DEN_W-1:0];
				div_quo_q <= {div_quo_q[DIV_W-2:0], trial_ge};
			end
			OP_SEG_SET: begin
				seg_q     <= seg_new;
				div_quo_q <= span_pos ? span_u : '0;
				div_den_q <= DEN_W'(seg_new);
				div_rem_q <= '0;
			end
			OP_QR_SET: begin
				q_q   <= span_pos ? $signed(div_quo_q) : {span30[34], span30};
				r_q   <= span_pos ? div_rem_q[SEG_W-1:0] : '0;
				num_q <= {1'b0, seg_q >> 1};
				off_q <= '0;
			end
			OP_RED_INIT: begin
				red_v_q <= red_init;
				quad_q  <= '0;
			end
			OP_RED_STEP: begin
				if (red_v_q >= red_cand) begin
					red_v_q <= red_v_q - red_cand;
					if (cmd.shift == 3'd0) begin
						quad_q[0] <= 1'b1;
					end
					if (cmd.shift == 3'd1) begin
						quad_q[1] <= 1'b1;
					end
				end
			end
			OP_FOLD: begin
				swap_q <= (res > QUARTPI);
				x_q    <= (res > QUARTPI) ? 30'(HALFPI - res) : res[29:0];
			end
			OP_SQR: begin
				x2_q <= sqr_prod[59:30];
			end
			OP_LDP: begin
				p_q <= {1'b0, x2_q};
			end
			OP_RCP: begin
				qr_q <= rcp_prod[62:32];
			end
			OP_COR: begin
				t_q <= t_new;
			end
			OP_MULT: begin
				p_q <= x2t_prod[60:30];
			end
			OP_SOUT: begin
				sin_q <= xt_prod[60:30];
			end
			OP_QUAD: begin
				case (quad_q)
					2'd0: begin
						c_q <= cc_s;
						s_q <= ss_s;
					end
					2'd1: begin
						c_q <= -ss_s;
						s_q <= cc_s;
					end
					2'd2: begin
						c_q <= -cc_s;
						s_q <= -ss_s;
					end
					default: begin
						c_q <= ss_s;
						s_q <= -cc_s;
					end
				endcase
			end
			OP_SCX: begin
				prod_q <= $signed({1'b0, rad}) * c_q;
			end
			OP_FINX: begin
				px_q <= coord_x;
			end
			OP_SCY: begin
				prod_q <= $signed({1'b0, rad}) * s_q;
			end
			OP_FINY: begin
				py_q <= coord_y;
			end
			OP_EMIT: begin
				o_fx_q   <= fx_q;
				o_fy_q   <= fy_q;
				o_sx_q   <= px_q;
				o_sy_q   <= py_q;
				o_last_q <= inner_q && (i_q == '0);
			end
			OP_FWD: begin
				num_q <= fwd_num;
				off_q <= off_q + q_q + 36'(fwd_wrap);
				if (!odd_q) begin
					fx_q <= px_q;
					fy_q <= py_q;
				end
			end
			OP_TURN: begin
				if (!odd_q) begin
					fx_q <= px_q;
					fy_q <= py_q;
				end
			end
			OP_BACK: begin
				num_q <= back_fix[SEG_W:0];
				off_q <= off_q - q_q - 36'(back_borrow);
				if (!odd_q) begin
					fx_q <= px_q;
					fy_q <= py_q;
				end
			end
			default: begin
			end
		endcase
	end

endmodule
`default_nettype wire

// ===== rtl/core/ring_sector_polygon_generator.sv =====
// top level of the ring sector polygon generator
// Takes one ring sector per input word on the s_ side: center, inner and
// outer radius, start and end angle. Emits the sector outline as point
// pairs on the m_ side, outer arc from the start angle forward, then the
// inner arc from the end angle back, with tlast on the final pair.
// Each sector yields seg+1 words, seg = ceil(span / (pi/30)) clamped to
// 1 .. MAX_POINTS/2-1.
// Setup runs a reciprocal estimate of the step count and its correction,
// then a 36-step serial division for the per-step angle. Each point then
// passes through range reduction, the sine and cosine polynomials and
// scaling, and every second point posts a word.
// s_tready is high only between sectors; the next sector is taken while
// the final word still waits in the output register.
// A stalled m_tready holds the current word and the generator pauses
// before posting the next one.
// Reset clears the sequencer and drops m_tvalid; no pass over storage.
`default_nettype none
module ring_sector_polygon_generator #(
	parameter int MAX_POINTS = 128
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	// center_x, center_y, inner_radius, outer_radius, start_angle, end_angle
	input  wire logic [rspg_pkg::IN_DATA_W-1:0]  s_tdata,
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	// first_x, first_y, second_x, second_y
	output logic [rspg_pkg::OUT_DATA_W-1:0]      m_tdata,
	output logic                                 m_tlast
);
	import rspg_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;
	logic    load;

	assign load = s_tvalid && s_tready;

	rspg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	rspg_dp #(
		.MAX_POINTS (MAX_POINTS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.load     (load),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule
`default_nettype wire

// ===== rtl/core/rspg_chk.sv =====
// port-level checks of the ring sector polygon generator
`default_nettype none
module rspg_chk (
	input wire logic                            clk,
	input wire logic                            arst_n,
	input wire logic                            s_tvalid,
	input wire logic                            s_tready,
	input wire logic                            m_tvalid,
	input wire logic                            m_tready,
	input wire logic [rspg_pkg::OUT_DATA_W-1:0] m_tdata,
	input wire logic                            m_tlast
);
	import rspg_pkg::*;

	// stalled word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output word changed under stall");

	// one sector at a time
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken twice in a row");

	// a new word is only posted while a sector is in flight
	a_post: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !$past(s_tready))
		else $error("word posted while idle");

	// a word that does not close the sector leaves the block busy
	a_mid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=> !s_tready)
		else $error("ready before the sector was closed");

endmodule

bind ring_sector_polygon_generator rspg_chk u_chk (.*);
`default_nettype wire

// ===== verif/tb_ring_sector_polygon_generator.sv =====
// testbench of the ring sector polygon generator: sectors in, predicted point pairs checked
`timescale 1ns / 100ps
`default_nettype none
module tb_ring_sector_polygon_generator;
	import rspg_pkg::*;

	localparam int MAX_PTS     = 128;
	localparam int QUIET_LIMIT = 3000;

	typedef struct packed {
		logic [13:0] first_x;
		logic [13:0] first_y;
		logic [13:0] second_x;
		logic [13:0] second_y;
		logic        last_pair;
	} point_pair_t;

	class sector_scoreboard;
		point_pair_t pairs_due[$];
		int          mismatches;
		logic [23:0] held_center;
		logic [31:0] held_radii;
		logic [31:0] held_angles;
		logic [6:0]  segment_count;
		logic [6:0]  point_step;
		logic        arc_phase;

		function new();
			mismatches = 0;
			held_center = '0;
			held_radii = '0;
			held_angles = '0;
			segment_count = '0;
			point_step = '0;
			arc_phase = 1'b0;
		endfunction

		function longint unsigned sin_q30(longint unsigned x);
			longint unsigned x2, t;
			x2 = (x * x) >> 30;
			t = 64'd1073741824 - x2 / 72;
			t = 64'd1073741824 - ((x2 * t) >> 30) / 42;
			t = 64'd1073741824 - ((x2 * t) >> 30) / 20;
			t = 64'd1073741824 - ((x2 * t) >> 30) / 6;
			return (x * t) >> 30;
		endfunction

		function longint unsigned cos_q30(longint unsigned x);
			longint unsigned x2, t;
			x2 = (x * x) >> 30;
			t = 64'd1073741824 - x2 / 90;
			t = 64'd1073741824 - ((x2 * t) >> 30) / 56;
			t = 64'd1073741824 - ((x2 * t) >> 30) / 30;
			t = 64'd1073741824 - ((x2 * t) >> 30) / 12;
			t = 64'd1073741824 - ((x2 * t) >> 30) / 2;
			return t;
		endfunction

		function void cos_sin(longint ang, output longint c, output longint s);
			longint unsigned twopi, r, q, res;
			longint cc, ss;
			twopi = 4 * 64'd1686629713;
			r = longint'(ang + 4 * longint'(twopi)) % twopi;
			q = r / 64'd1686629713;
			res = r - q * 64'd1686629713;
			// fold the upper half of the quadrant onto the lower one
			if (res > 64'd843314856) begin
				cc = longint'(sin_q30(64'd1686629713 - res));
				ss = longint'(cos_q30(64'd1686629713 - res));
			end else begin
				cc = longint'(cos_q30(res));
				ss = longint'(sin_q30(res));
			end
			case (q[1:0])
				2'd0: begin c = cc; s = ss; end
				2'd1: begin c = -ss; s = cc; end
				2'd2: begin c = -cc; s = -ss; end
				default: begin c = ss; s = -cc; end
			endcase
		endfunction

		function longint pixel_offset(longint unsigned rad, longint t);
			longint v;
			v = longint'(rad) * t + 64'sd8589934592;
			if (v >= 0)
				return longint'(longint'(unsigned'(v)) >>> 34);
			return -longint'(longint'(-v) >>> 34);
		endfunction

		function void note_sector(logic [87:0] d);
			longint cx, cy, a0, span, off, c, s, x, y;
			longint unsigned rin, rout, seg, npts, i, rad;
			point_pair_t pp;
			cx = longint'(d[11:0]);
			cy = longint'(d[23:12]);
			rin = d[39:24];
			rout = d[55:40];
			a0 = longint'($signed(d[71:56])) * 262144;
			span = longint'($signed(d[87:72])) * 262144 - a0;
			seg = 1;
			if (span > 0)
				seg = (longint'(span) + 64'd112441981 - 1) / 64'd112441981;
			if (seg < 1)
				seg = 1;
			if (2 * (seg + 1) > MAX_PTS)
				seg = MAX_PTS / 2 - 1;
			npts = 2 * (seg + 1);
			held_center = d[23:0];
			held_radii = d[55:24];
			held_angles = d[87:56];
			segment_count = seg[6:0];
			pp = '0;
			for (longint unsigned p = 0; p < npts; p++) begin
				if (p <= seg) begin
					i = p;
					rad = rout;
					arc_phase = 1'b0;
				end else begin
					i = 2 * seg + 1 - p;
					rad = rin;
					arc_phase = 1'b1;
				end
				if (span > 0)
					off = longint'((longint'(span) * i + seg / 2) / seg);
				else
					off = span * longint'(i);
				cos_sin(a0 + off, c, s);
				x = cx + pixel_offset(rad, c);
				y = cy + pixel_offset(rad, s);
				point_step = i[6:0];
				if (p[0] == 1'b0) begin
					pp.first_x = x[13:0];
					pp.first_y = y[13:0];
				end else begin
					pp.second_x = x[13:0];
					pp.second_y = y[13:0];
					pp.last_pair = (p + 1 == npts);
					pairs_due.push_back(pp);
				end
			end
		endfunction

		function void check_pair(logic [55:0] d, logic last);
			point_pair_t got, want;
			got = {d[13:0], d[27:14], d[41:28], d[55:42], last};
			if (pairs_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word %h last %b", d, last);
				return;
			end
			want = pairs_due.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("pair mismatch: want %0d,%0d %0d,%0d last %b, got %0d,%0d %0d,%0d last %b",
						$signed(want.first_x), $signed(want.first_y), $signed(want.second_x),
						$signed(want.second_y), want.last_pair, $signed(got.first_x),
						$signed(got.first_y), $signed(got.second_x), $signed(got.second_y),
						got.last_pair);
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tlast;

	sector_scoreboard sb;
	int               quiet_cycles;

	ring_sector_polygon_generator #(.MAX_POINTS(MAX_PTS)) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// the scoreboard sees both sides at the edge, before any driven change lands
	always @(posedge clk) begin
		if (s_tvalid && s_tready)
			sb.note_sector(s_tdata);
		if (m_tvalid && m_tready)
			sb.check_pair(m_tdata, m_tlast);
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	always @(posedge clk) begin
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	function automatic int draw_gap();
		// at least a quarter of the draws give back-to-back words
		if ($urandom_range(0, 3) == 0)
			return 0;
		return $urandom_range(0, 15);
	endfunction

	task automatic send_sector(logic [11:0] cx, logic [11:0] cy, logic [15:0] rin,
		logic [15:0] rout, logic [15:0] a0, logic [15:0] a1);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {a1, a0, rout, rin, cy, cx};
		do @(negedge clk); while (!s_tready);
		@(posedge clk);
	endtask

	task automatic send_random_sector();
		logic [15:0] a0, a1;
		int          span;
		a0 = 16'($urandom);
		if ($urandom_range(0, 7) == 0) begin
			a1 = 16'($urandom);
		end else begin
			span = int'($signed(a0)) + int'($urandom_range(0, 2000));
			a1 = (span > 32767) ? 16'sd32767 : 16'(span);
		end
		send_sector(12'($urandom), 12'($urandom), 16'($urandom), 16'($urandom), a0, a1);
	endtask

	// output side: random stall before each word
	initial begin
		int stall;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = draw_gap();
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(negedge clk); while (!m_tvalid);
			@(posedge clk);
		end
	end

	initial begin
		sb = new();
		quiet_cycles = 0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: field extremes, zero and negative span, swapped radii, capped span
		send_sector(12'd0, 12'd0, 16'd0, 16'd0, 16'd0, 16'd0);
		send_sector(12'd4095, 12'd4095, 16'd65535, 16'd65535, 16'd0, 16'd0);
		send_sector(12'd2048, 12'd2048, 16'd100, 16'd800, 16'd4096, 16'd0);
		send_sector(12'd100, 12'd4000, 16'd900, 16'd300, 16'd0, 16'd6434);
		send_sector(12'd0, 12'd4095, 16'd65535, 16'd0, 16'h8000, 16'h7fff);
		send_sector(12'd4095, 12'd0, 16'd0, 16'd65535, 16'h7fff, 16'h8000);
		send_sector(12'd1000, 12'd1000, 16'd1600, 16'd3200, 16'h8000, 16'h8000);
		send_sector(12'd1000, 12'd1000, 16'd1600, 16'd3200, 16'h7fff, 16'h7fff);
		send_sector(12'd500, 12'd500, 16'd160, 16'd320, 16'd0, 16'd429);
		send_sector(12'd500, 12'd500, 16'd160, 16'd320, 16'd0, 16'd428);
		send_sector(12'd500, 12'd500, 16'd160, 16'd320, 16'd0, 16'd1);
		send_sector(12'd3000, 12'd1200, 16'd40000, 16'd65535, 16'hd000, 16'h3000);
		send_sector(12'd2000, 12'd2000, 16'd4000, 16'd8000, 16'd6434, 16'd12868);
		send_sector(12'd2000, 12'd2000, 16'd4000, 16'd8000, 16'hcdbc, 16'd0);
		send_sector(12'd7, 12'd9, 16'd65535, 16'd1, 16'd0, 16'd25735);

		repeat (195) send_random_sector();
		s_tvalid <= 1'b0;

		while (sb.pairs_due.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		if (sb.mismatches == 0 && sb.pairs_due.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
`default_nettype wire

// ===== filelist.f =====
rtl/core/rspg_pkg.sv
rtl/core/rspg_ctrl.sv
rtl/core/rspg_dp.sv
rtl/core/ring_sector_polygon_generator.sv
rtl/core/rspg_chk.sv
verif/tb_ring_sector_polygon_generator.sv
